/* rtl/edf_pkg.sv */
`default_nettype none
package edf_pkg;

  localparam int unsigned QUEUE_CAPACITY = 64;
  localparam int unsigned IDX_W = $clog2(QUEUE_CAPACITY);
  localparam int unsigned CNT_W = $clog2(QUEUE_CAPACITY + 1);
  localparam logic [15:0] HORIZON_RESET = 16'd1024;

  localparam logic [1:0] REQ_CLEAR    = 2'd0;
  localparam logic [1:0] REQ_ADD      = 2'd1;
  localparam logic [1:0] REQ_DISPATCH = 2'd2;
  // unused code: no result, no state change
  localparam logic [1:0] REQ_NONE     = 2'd3;

  localparam logic [2:0] STAT_CLEARED    = 3'd0;
  localparam logic [2:0] STAT_ADDED      = 3'd1;
  localparam logic [2:0] STAT_DROPPED    = 3'd2;
  localparam logic [2:0] STAT_DISPATCHED = 3'd3;
  localparam logic [2:0] STAT_IDLE       = 3'd4;
  localparam logic [2:0] STAT_EMPTY      = 3'd5;
  localparam logic [2:0] STAT_BAD_PERIOD = 3'd6;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  task_pid;
    logic [15:0] exec_time;
    logic [15:0] task_period;
    logic [15:0] task_phase;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  job_pid;
    logic [15:0] issue_time;
    logic [15:0] run_time;
    logic [15:0] job_deadline;
    logic [6:0]  jobs_added;
  } res_t;

  typedef struct packed {
    logic [7:0]  pid;
    logic [15:0] exec;
    logic [15:0] period;
    logic [15:0] deadline;
    logic [7:0]  seq;
  } job_t;

  // core to top handshake status
  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_stat_t;

endpackage
`default_nettype wire

/* rtl/edf_core.sv */
`default_nettype none
module edf_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire edf_pkg::req_t      req,
  input  wire logic [15:0]        horizon,
  input  wire logic               res_ready,
  output edf_pkg::core_stat_t     stat,
  output edf_pkg::res_t           res
);
  import edf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ADD      = 7'b0000010,
    S_SCAN_RD  = 7'b0000100,
    S_SCAN_CMP = 7'b0001000,
    S_MOVE_RD  = 7'b0010000,
    S_MOVE_WR  = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  req_t req_r, req_nxt;
  res_t res_r, res_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0] time_r, time_nxt;
  logic [7:0] seq_r, seq_nxt;
  logic [16:0] dl_r, dl_nxt;
  logic [6:0] added_r, added_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic found_r, found_nxt;
  job_t best_r, best_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;

  job_t job_mem [QUEUE_CAPACITY];
  job_t rdata_r;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic wr_en;
  job_t wr_data;

  logic [CNT_W-1:0] last_cnt;
  logic [16:0] rel_diff, time_sum;
  logic released, better;

  assign last_cnt = count_r - CNT_W'(1);
  assign rd_addr  = (state_r == S_MOVE_RD) ? last_cnt[IDX_W-1:0] : idx_r;

  always_ff @(posedge clk) begin
    if (wr_en) job_mem[wr_addr] <= wr_data;
    rdata_r <= job_mem[rd_addr];
  end

  // shared release / key compare
  assign rel_diff = {1'b0, rdata_r.deadline} - {1'b0, rdata_r.period};
  assign released = !rel_diff[16] && (rel_diff[15:0] <= time_r);
  assign better   = !found_r || (rdata_r.deadline < best_r.deadline) ||
                    ((rdata_r.deadline == best_r.deadline) && (rdata_r.seq < best_r.seq));
  assign time_sum = {1'b0, time_r} + {1'b0, best_r.exec};

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    res_nxt      = res_r;
    count_nxt    = count_r;
    time_nxt     = time_r;
    seq_nxt      = seq_r;
    dl_nxt       = dl_r;
    added_nxt    = added_r;
    idx_nxt      = idx_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    wr_en        = 1'b0;
    wr_addr      = count_r[IDX_W-1:0];
    wr_data      = '{pid: req_r.task_pid, exec: req_r.exec_time, period: req_r.task_period,
                     deadline: dl_r[15:0], seq: seq_r};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = req;
          res_nxt = '0;
          case (req.req_type)
            REQ_CLEAR: begin
              count_nxt = '0;
              time_nxt  = '0;
              seq_nxt   = '0;
              res_nxt.status = STAT_CLEARED;
              state_nxt = S_DONE;
            end
            REQ_ADD: begin
              if (req.task_period == 16'd0) begin
                res_nxt.status = STAT_BAD_PERIOD;
                state_nxt = S_DONE;
              end else begin
                dl_nxt    = {1'b0, req.task_phase} + {1'b0, req.task_period};
                added_nxt = '0;
                state_nxt = S_ADD;
              end
            end
            REQ_DISPATCH: begin
              if (count_r == '0) begin
                res_nxt.status     = STAT_EMPTY;
                res_nxt.issue_time = time_r;
                state_nxt = S_DONE;
              end else begin
                idx_nxt   = '0;
                found_nxt = 1'b0;
                state_nxt = S_SCAN_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_ADD: begin
        if (dl_r < {1'b0, horizon}) begin
          if (count_r < CNT_W'(QUEUE_CAPACITY)) begin
            wr_en     = 1'b1;
            seq_nxt   = seq_r + 8'd1;
            count_nxt = count_r + CNT_W'(1);
            added_nxt = added_r + 7'd1;
            dl_nxt    = dl_r + {1'b0, req_r.task_period};
          end else begin
            res_nxt.status     = STAT_DROPPED;
            res_nxt.jobs_added = added_r;
            state_nxt = S_DONE;
          end
        end else begin
          res_nxt.status     = STAT_ADDED;
          res_nxt.jobs_added = added_r;
          state_nxt = S_DONE;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (released && better) begin
          found_nxt    = 1'b1;
          best_nxt     = rdata_r;
          best_idx_nxt = idx_r;
        end
        idx_nxt = idx_r + IDX_W'(1);
        if ({1'b0, idx_r} == last_cnt) begin
          if (found_nxt) begin
            state_nxt = S_MOVE_RD;
          end else begin
            time_nxt = (time_r == 16'hFFFF) ? time_r : time_r + 16'd1;
            res_nxt.status     = STAT_IDLE;
            res_nxt.issue_time = time_r;
            res_nxt.run_time   = 16'd1;
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_MOVE_RD: state_nxt = S_MOVE_WR;
      S_MOVE_WR: begin
        // last entry fills the hole left by the picked job
        wr_en     = 1'b1;
        wr_addr   = best_idx_r;
        wr_data   = rdata_r;
        count_nxt = last_cnt;
        time_nxt  = time_sum[16] ? 16'hFFFF : time_sum[15:0];
        res_nxt.status       = STAT_DISPATCHED;
        res_nxt.job_pid      = best_r.pid;
        res_nxt.issue_time   = time_r;
        res_nxt.run_time     = best_r.exec;
        res_nxt.job_deadline = best_r.deadline;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      time_r  <= '0;
      seq_r   <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      time_r  <= time_nxt;
      seq_r   <= seq_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    dl_r       <= dl_nxt;
    added_r    <= added_nxt;
    idx_r      <= idx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
  end

  assign stat.idle      = (state_r == S_IDLE);
  assign stat.res_valid = (state_r == S_DONE);
  assign res = res_r;

endmodule
`default_nettype wire

/* rtl/edf_job_dispatcher_core.sv */
`default_nettype none
// EDF job dispatcher. Requests come in one beat at a time: clear, add a
// periodic task (expanded into jobs with deadline phase+k*period below the
// horizon register), or dispatch the released job with the earliest deadline
// (ties to the older insertion). One request is in flight at a time; in_stall
// stays high from acceptance until its result has moved to the output
// register, and a new request is taken while that result still waits there.
// Steps: clear, bad period and empty dispatch go straight to the result;
// add writes one job per step until the deadline walk reaches the horizon;
// dispatch scans the 64-entry job memory with one read and one compare per
// queued job (on the shared release/key comparator), then back-fills the
// removed slot from the last entry. Request code 3 is swallowed without a
// result. horizon is to be written only while the block is quiet; the block
// itself does not enforce this.
module edf_job_dispatcher_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire edf_pkg::req_t    in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output edf_pkg::res_t         out_data,
  input  wire logic             cfg_we,
  input  wire logic [15:0]      cfg_data
);
  import edf_pkg::*;

  logic [15:0] horizon_r;
  logic out_valid_r;
  res_t out_data_r;
  core_stat_t stat;
  res_t res;
  logic res_ready, in_beat;

  assign in_stall  = !stat.idle;
  assign in_beat   = in_valid && !in_stall;
  // output register empty or being drained this cycle
  assign res_ready = !out_valid_r || !out_stall;

  edf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_beat),
    .req       (in_data),
    .horizon   (horizon_r),
    .res_ready (res_ready),
    .stat      (stat),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_r   <= HORIZON_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) horizon_r <= cfg_data;
      if (res_ready) out_valid_r <= stat.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && stat.res_valid) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a real request keeps the port busy on the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_beat && (in_data.req_type != REQ_NONE)) |=> in_stall)
    else $error("request accepted but core not busy");

  // a result handed over shows up on the output next cycle
  a_res_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && stat.res_valid && res_ready) |=> out_valid)
    else $error("result lost between core and output register");

  // idle tick always reports run time one
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STAT_IDLE)) |-> (out_data.run_time == 16'd1))
    else $error("idle tick with wrong run time");

endmodule
`default_nettype wire
